// ----- rtl/u8dl_pkg.sv -----
// Package: widths, codepoint constants and combining-mark decode for the UTF-8 length counter.
package u8dl_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned CP_WIDTH    = 21;
  localparam int unsigned OUT_WIDTH   = 32;

  typedef logic [CP_WIDTH-1:0]    cp_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam cp_t CP_JOINER = 21'h00200D;
  localparam logic [5:0] CONT_MASK = 6'h3F;

  localparam cp_t MARK0_LO = 21'h000300;
  localparam cp_t MARK0_HI = 21'h00036F;
  localparam cp_t MARK1_LO = 21'h001AB0;
  localparam cp_t MARK1_HI = 21'h001AFF;
  localparam cp_t MARK2_LO = 21'h001DC0;
  localparam cp_t MARK2_HI = 21'h001DFF;
  localparam cp_t MARK3_LO = 21'h0020D0;
  localparam cp_t MARK3_HI = 21'h0020FF;
  localparam cp_t MARK4_LO = 21'h00FE20;
  localparam cp_t MARK4_HI = 21'h00FE2F;

  function automatic logic is_mark(cp_t cp);
    return (cp >= MARK0_LO && cp <= MARK0_HI) ||
           (cp >= MARK1_LO && cp <= MARK1_HI) ||
           (cp >= MARK2_LO && cp <= MARK2_HI) ||
           (cp >= MARK3_LO && cp <= MARK3_HI) ||
           (cp >= MARK4_LO && cp <= MARK4_HI);
  endfunction

endpackage

// ----- rtl/utf8_display_length_counter_unit.sv -----
// Top level: UTF-8 display length counter, one byte per cycle while both output slots are not full, batch total out.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | data_byte_i, byte_present_i,
//          |           |                        | end_of_string_i, end_of_batch_i
//  out     | output    | out_valid_o/out_ready_i | display_length_o (32 bit)
//
// One byte transaction per cycle; the total is registered at the end-of-batch accept
// edge and shows on the output the next cycle unless an older total still waits there.
// Decode state is a single register set updated in the accept cycle.
// Reset clears decode state, count and the valid flags of both output slots.
// Output has a result register plus a skid slot: input keeps flowing while one
// result waits; it stalls only when both slots are full.
module utf8_display_length_counter_unit
  import u8dl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_string_i,
  input  logic        end_of_batch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] display_length_o
);

  // decode state
  cp_t        acc_q, acc_d;
  logic [1:0] exp_q, exp_d;
  logic       jtp_q, jtp_d;
  logic       lwb_q, lwb_d;
  count_t     cnt_q, cnt_d;

  // output slots
  logic                 out_v_q, out_v_d;
  logic [OUT_WIDTH-1:0] out_q, out_d;
  logic                 skid_v_q, skid_v_d;
  logic [OUT_WIDTH-1:0] skid_q, skid_d;

  logic in_acc, push, pop;

  assign in_ready_o = ~skid_v_q;
  assign in_acc     = in_valid_i & in_ready_o;
  assign push       = in_acc & end_of_batch_i;
  assign pop        = out_v_q & out_ready_i;

  // byte stage results
  cp_t        acc1;
  logic [1:0] exp1;
  logic       take;
  cp_t        cp;
  cp_t        pad_cp;
  logic       str_end;
  // codepoint stage results
  logic       lwb2, jtp2, inc;
  count_t     cnt_bumped;
  logic [OUT_WIDTH-1:0] total;

  always_comb begin
    acc1    = acc_q;
    exp1    = exp_q;
    take    = 1'b0;
    cp      = '0;
    str_end = end_of_string_i | end_of_batch_i;

    if (byte_present_i) begin
      if (exp_q != 2'd0) begin
        // continuation: low six bits shifted in, top bits fall off
        acc1 = {acc_q[CP_WIDTH-7:0], data_byte_i[5:0] & CONT_MASK};
        exp1 = exp_q - 2'd1;
        if (exp1 == 2'd0) begin
          take = 1'b1;
          cp   = acc1;
        end
      end else if (!data_byte_i[7]) begin
        take = 1'b1;
        cp   = {13'd0, data_byte_i};
      end else if (data_byte_i[7:5] == 3'b110) begin
        acc1 = {16'd0, data_byte_i[4:0]};
        exp1 = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        acc1 = {17'd0, data_byte_i[3:0]};
        exp1 = 2'd2;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        acc1 = {18'd0, data_byte_i[2:0]};
        exp1 = 2'd3;
      end else begin
        // invalid lead: plain one-byte codepoint
        take = 1'b1;
        cp   = {13'd0, data_byte_i};
      end
    end

    // truncated sequence at string end: pad with zero continuation bytes
    case (exp1)
      2'd1:    pad_cp = {acc1[CP_WIDTH-7:0], 6'd0};
      2'd2:    pad_cp = {acc1[CP_WIDTH-13:0], 12'd0};
      2'd3:    pad_cp = {acc1[CP_WIDTH-19:0], 18'd0};
      default: pad_cp = acc1;
    endcase
    if (str_end && exp1 != 2'd0) begin
      take = 1'b1;
      cp   = pad_cp;
    end

    // joiner / mark handling for the one codepoint this item may produce
    lwb2 = lwb_q;
    jtp2 = jtp_q;
    inc  = 1'b0;
    if (take) begin
      if (lwb_q && cp == CP_JOINER) begin
        lwb2 = 1'b0;
        jtp2 = 1'b1;
      end else begin
        if (lwb_q) begin
          lwb2 = 1'b0;
          jtp2 = 1'b0;
        end
        if (!is_mark(cp)) begin
          inc  = ~jtp2;
          lwb2 = 1'b1;
        end
      end
    end

    cnt_bumped = (inc && cnt_q != '1) ? cnt_q + count_t'(1) : cnt_q;
    // saturate into the 32-bit result
    total = ((cnt_bumped >> OUT_WIDTH) != '0) ? '1 : OUT_WIDTH'(cnt_bumped);

    acc_d = acc_q;
    exp_d = exp_q;
    jtp_d = jtp_q;
    lwb_d = lwb_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      if (str_end) begin
        acc_d = '0;
        exp_d = 2'd0;
        jtp_d = 1'b0;
        lwb_d = 1'b0;
      end else begin
        acc_d = acc1;
        exp_d = exp1;
        jtp_d = jtp2;
        lwb_d = lwb2;
      end
      cnt_d = end_of_batch_i ? '0 : cnt_bumped;
    end
  end

  // result register and skid slot
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_d   = total;
        out_v_d = 1'b1;
      end else begin
        skid_d   = total;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      exp_q    <= 2'd0;
      jtp_q    <= 1'b0;
      lwb_q    <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      exp_q    <= exp_d;
      jtp_q    <= jtp_d;
      lwb_q    <= lwb_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_v_q;
  assign display_length_o = out_q;

`ifndef SYNTHESIS
  // skid slot only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot valid without result register valid");

  // a string end leaves no open sequence and no joiner state
  a_string_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (end_of_string_i || end_of_batch_i)) |=>
      (exp_q == 2'd0 && !jtp_q && !lwb_q && acc_q == '0))
    else $error("decode state not cleared at string end");

  // batch end restarts the count and yields a result
  a_batch_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (cnt_q == '0 && out_v_q))
    else $error("batch end did not restart count or post a result");
`endif

endmodule

// ----- tb/sv/tb_utf8_display_length_counter_unit.sv -----
// Testbench: self-checking stimulus and batch-total checks for the UTF-8 display length counter.
`timescale 1ns / 100ps

module tb_utf8_display_length_counter_unit;
  import u8dl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned SETTLE_TICKS = 10;

  // One input transaction as queued for the driver. 'drain' makes the driver hold this
  // transaction back until every batch total still owed has been seen.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eos;
    logic       eob;
    logic       drain;
  } byte_txn_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i      = 8'h00;
  logic        byte_present_i   = 1'b0;
  logic        end_of_string_i  = 1'b0;
  logic        end_of_batch_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [31:0] display_length_o;

  utf8_display_length_counter_unit dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_txn_t   byte_txn_q[$];   // transactions waiting for the driver
  logic [31:0] length_q[$];     // batch totals owed by the DUT, oldest first
  byte_txn_t   cur_txn;
  int unsigned txns_done    = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  logic        drain_next   = 1'b0;

  // Idling is switched off for a stretch in the middle of the run.
  wire calm = (txns_done >= 500) && (txns_done < 900);

  // ---------------------------------------------------------------------------
  // Length predictor: mirrors the decode state of the block.
  // ---------------------------------------------------------------------------
  cp_t         cp_acc     = '0;  // codepoint bits gathered so far
  logic [1:0]  cont_left  = '0;  // continuation bytes still owed
  logic        glued      = 1'b0; // joiner absorbed: next base is not counted
  logic        after_base = 1'b0; // previous codepoint was a base, a joiner would glue
  count_t      run_count  = '0;

  function automatic logic is_combining(cp_t cp);
    return (cp >= 21'h000300 && cp <= 21'h00036F) ||
           (cp >= 21'h001AB0 && cp <= 21'h001AFF) ||
           (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
           (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
           (cp >= 21'h00FE20 && cp <= 21'h00FE2F);
  endfunction

  task automatic cp_take(input cp_t cp);
    if (after_base) begin
      after_base = 1'b0;
      // a joiner right after a base is swallowed and glues the next base on
      if (cp == CP_JOINER) begin
        glued = 1'b1;
        return;
      end
      glued = 1'b0;
    end
    if (is_combining(cp)) return;
    if (!glued && run_count != '1) run_count = run_count + 1'b1;
    after_base = 1'b1;
  endtask

  task automatic byte_take(input logic [7:0] b);
    if (cont_left != 0) begin
      // anything inside an open sequence is a continuation, top bits ignored
      cp_acc    = (cp_acc << 6) | cp_t'(b[5:0]);
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) cp_take(cp_acc);
      return;
    end
    if (b[7] == 1'b0) begin
      cp_take(cp_t'(b));
    end else if (b[7:5] == 3'b110) begin
      cp_acc    = cp_t'(b[4:0]);
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc    = cp_t'(b[3:0]);
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc    = cp_t'(b[2:0]);
      cont_left = 2'd3;
    end else begin
      // stray continuation or 0xF8..0xFF: a base of its own
      cp_take(cp_t'(b));
    end
  endtask

  task automatic string_close();
    cp_t padded;
    // truncated sequence: missing bytes count as zero
    if (cont_left != 0) begin
      padded = cp_acc << (6 * cont_left);
      cp_take(padded);
    end
    cp_acc     = '0;
    cont_left  = '0;
    glued      = 1'b0;
    after_base = 1'b0;
  endtask

  task automatic length_predict(input byte_txn_t t);
    if (t.present) byte_take(t.data);
    if (t.eos || t.eob) string_close();
    if (t.eob) begin
      length_q.insert(length_q.size(),
                      (run_count > count_t'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                             : 32'(run_count));
      run_count = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_txn(input logic [7:0] d, input logic pr, input logic eos,
                          input logic eob);
    byte_txn_t t;
    t.data     = d;
    t.present  = pr;
    t.eos      = eos;
    t.eob      = eob;
    t.drain    = drain_next;
    drain_next = 1'b0;
    byte_txn_q.insert(byte_txn_q.size(), t);
  endtask

  // Encode cp in n bytes (overlong allowed), push the first 'keep' of them; the end
  // flags go on the last byte pushed.
  task automatic push_cp(input cp_t cp, input int n, input int keep, input logic eos,
                         input logic eob);
    logic [7:0] seq [4];
    int         i;
    case (n)
      1: seq[0] = cp[7:0];
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    // continuation top bits are not checked by the block, so scramble them now and then
    for (i = 1; i < n; i++) begin
      if ($urandom_range(9) == 0) seq[i][7:6] = 2'($urandom_range(3));
    end
    for (i = 0; i < keep; i++) begin
      push_txn(seq[i], 1'b1, (i == keep - 1) ? eos : 1'b0, (i == keep - 1) ? eob : 1'b0);
    end
  endtask

  function automatic int min_len(cp_t cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic rand_cp(output cp_t cp, output int n);
    int   r;
    int   pick;
    cp_t  lo;
    cp_t  hi;
    r = $urandom_range(99);
    if (r < 25) begin
      cp = cp_t'($urandom_range(8'h7F));
      n  = 1;
    end else if (r < 35) begin
      cp = cp_t'($urandom_range(11'h7FF));
      n  = 2;
    end else if (r < 45) begin
      cp = cp_t'($urandom_range(16'hFFFF));
      n  = 3;
    end else if (r < 52) begin
      cp = cp_t'($urandom_range(21'h1FFFFF));
      n  = 4;
    end else if (r < 67) begin
      // combining mark, with the range edges and the codepoints just outside
      case ($urandom_range(4))
        0: begin lo = MARK0_LO; hi = MARK0_HI; end
        1: begin lo = MARK1_LO; hi = MARK1_HI; end
        2: begin lo = MARK2_LO; hi = MARK2_HI; end
        3: begin lo = MARK3_LO; hi = MARK3_HI; end
        default: begin lo = MARK4_LO; hi = MARK4_HI; end
      endcase
      pick = $urandom_range(9);
      case (pick)
        0: cp = lo - 1'b1;
        1: cp = lo;
        2: cp = hi;
        3: cp = hi + 1'b1;
        default: cp = cp_t'($urandom_range(hi, lo));
      endcase
      n = min_len(cp);
      if (n < 4 && $urandom_range(4) == 0) n = n + 1;
    end else if (r < 82) begin
      cp = CP_JOINER;
      n  = ($urandom_range(5) == 0) ? 4 : 3;
    end else if (r < 90) begin
      // invalid lead byte
      cp = cp_t'($urandom_range(1) ? $urandom_range(8'hBF, 8'h80)
                                   : $urandom_range(8'hFF, 8'hF8));
      n  = 1;
    end else begin
      cp = cp_t'($urandom_range(8'hFF));
      n  = 1;
    end
  endtask

  task automatic build_random();
    int          batch_no;
    int          nstr;
    int          ncp;
    int          s;
    int          c;
    int          n;
    int          keep;
    logic        last_str;
    logic        eos;
    logic        eob;
    logic        tag_last;
    logic        fin;
    cp_t         cp;
    batch_no = 0;
    while (byte_txn_q.size() < ITEM_TARGET) begin
      nstr = $urandom_range(4, 1);
      if (batch_no % 40 == 17 || $urandom_range(29) == 0) drain_next = 1'b1;
      for (s = 0; s < nstr; s++) begin
        last_str = (s == nstr - 1);
        eob      = last_str;
        // the batch end may also end the string by itself
        eos      = !(last_str && $urandom_range(4) == 0);
        ncp      = ($urandom_range(19) == 0) ? $urandom_range(30, 10) : $urandom_range(6);
        tag_last = 1'($urandom_range(1));
        for (c = 0; c < ncp; c++) begin
          rand_cp(cp, n);
          keep = (n > 1 && $urandom_range(11) == 0) ? $urandom_range(n - 1, 1) : n;
          fin  = (c == ncp - 1) || (keep != n);
          // idle transaction, no byte and no end: must change nothing
          if ($urandom_range(29) == 0) push_txn(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
          push_cp(cp, n, keep, fin && tag_last && eos, fin && tag_last && eob);
          if (fin) break;
        end
        if (!tag_last || ncp == 0) push_txn(8'($urandom_range(255)), 1'b0, eos, eob);
      end
      batch_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction from byte_txn_q at a time, random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        length_predict(cur_txn);
        txns_done++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_txn_q.size() != 0 && !(byte_txn_q[0].drain && length_q.size() != 0) &&
            (calm || $urandom_range(99) >= 17)) begin
          cur_txn          = byte_txn_q.pop_front();
          in_valid_i      <= 1'b1;
          data_byte_i     <= cur_txn.data;
          byte_present_i  <= cur_txn.present;
          end_of_string_i <= cur_txn.eos;
          end_of_batch_i  <= cur_txn.eob;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random ready with occasional long stalls; checks each batch total.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (length_q.size() == 0) begin
          $display("%0t: result with none expected: got %0d", $time, display_length_o);
          errors++;
        end else begin
          want = length_q.pop_front();
          if (display_length_o !== want) begin
            $display("%0t: display_length mismatch: expected %0d, got %0d",
                     $time, want, display_length_o);
            errors++;
          end
        end
      end
      // long stalls let both result slots fill so the input side gets back-pressure
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(499) == 0) begin
        hold_left = $urandom_range(40, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_utf8_display_length_counter_unit: done, errors");
      $finish;
    end
  end

  initial begin
    // empty string alone in a batch
    push_txn(8'h00, 1'b0, 1'b1, 1'b1);
    // ASCII extremes; batch ends without a string end
    push_txn(8'h41, 1'b1, 1'b1, 1'b0);
    push_txn(8'h00, 1'b1, 1'b0, 1'b0);
    push_txn(8'h7F, 1'b1, 1'b0, 1'b1);
    // base + combining mark, idle transaction, joiner gluing a 4-byte emoji;
    // the sender waits for the earlier totals first
    drain_next = 1'b1;
    push_txn(8'h65, 1'b1, 1'b0, 1'b0);
    push_cp(21'h000301, 2, 2, 1'b0, 1'b0);
    push_txn(8'hA5, 1'b0, 1'b0, 1'b0);
    push_cp(CP_JOINER, 3, 3, 1'b0, 1'b0);
    push_cp(21'h01F600, 4, 4, 1'b1, 1'b1);
    // leading joiner, joiner after it, invalid leads, lead inside a sequence,
    // truncated sequence at the end
    push_cp(CP_JOINER, 3, 3, 1'b0, 1'b0);
    push_cp(CP_JOINER, 3, 3, 1'b0, 1'b0);
    push_txn(8'hFF, 1'b1, 1'b0, 1'b0);
    push_txn(8'h80, 1'b1, 1'b0, 1'b0);
    push_txn(8'hE2, 1'b1, 1'b0, 1'b0);
    push_txn(8'hF0, 1'b1, 1'b0, 1'b0);
    push_txn(8'h80, 1'b1, 1'b0, 1'b0);
    push_txn(8'hF0, 1'b1, 1'b0, 1'b0);
    push_txn(8'h9F, 1'b1, 1'b1, 1'b1);
    build_random();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_txn_q.size() != 0 || in_valid_i || length_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_utf8_display_length_counter_unit: done, clean");
    end else begin
      $display("tb_utf8_display_length_counter_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/u8dl_pkg.sv
rtl/utf8_display_length_counter_unit.sv
tb/sv/tb_utf8_display_length_counter_unit.sv
